FILE: sv/dew_point_from_temp_rh_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dew point core
// Concurrent checks, clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEW_POINT_FROM_TEMP_RH_CORE_ASSERT_SVH
`define DEW_POINT_FROM_TEMP_RH_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define DPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dew point core check failed");
// antecedent implies consequent in the next cycle
`define DPT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dew point core check failed");
`else
`define DPT_ASSERT_IMP(lbl, ante, cons)
`define DPT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/dpt_pkg.sv
// ----------------------------------------------------------------------------
// dpt_pkg
// Constants and the humidity log table of the dew point core.
// ----------------------------------------------------------------------------
package dpt_pkg;

    localparam int TEMP_W = 15;
    localparam int RH_W   = 7;
    localparam int DEW_W  = 16;
    localparam int LOG_W  = 24;   // signed Q4.20

    localparam logic signed [16:0] LAMBDA_CENTI = 17'sd24312;
    localparam logic signed [25:0] BETA_Q20     = 26'sd18475909;
    localparam logic [RH_W-1:0]    RH_MAX       = 7'd100;

    typedef logic [100:0][LOG_W-1:0] log_tab_t;

    // ln(RH/100) in Q4.20 for every humidity 0..100, built at elaboration
    function automatic log_tab_t build_log_tab();
        log_tab_t tab;
        longint   s;
        longint   m;
        longint   a;
        longint   t;
        longint   p;
        longint   q;
        longint   sum;
        longint   num;
        for (int rh = 0; rh <= 100; rh++) begin
            if (rh == 0) begin
                tab[rh] = LOG_W'(-64'sd5 * 64'sd1048576);
            end else begin
                s = 0;
                for (int k = 0; k < 7; k++) begin
                    if ((longint'(rh) << s) < 100) begin
                        s = s + 1;
                    end
                end
                m   = (longint'(rh) << (20 + s)) / 100;
                a   = m / 3;
                t   = 2 * 1048576 - a;
                p   = (t * m) >>> 20;
                q   = p - 699050;
                sum = q + (-s - 1) * 1048576;
                num = sum * 726663;
                tab[rh] = LOG_W'(num / 1048576);
            end
        end
        return tab;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

FILE: sv/dpt_if.sv
// ----------------------------------------------------------------------------
// dpt_if
// Valid/ready channels of the dew point core: readings in, dew points out.
// ----------------------------------------------------------------------------
interface dpt_in_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] temp_centi_c;
    logic        [6:0]  rel_humidity;

    modport source (output valid, temp_centi_c, rel_humidity, input ready);
    modport sink   (input valid, temp_centi_c, rel_humidity, output ready);
endinterface

interface dpt_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dew_point_centi_c;

    modport source (output valid, dew_point_centi_c, input ready);
    modport sink   (input valid, dew_point_centi_c, output ready);
endinterface

FILE: sv/dpt_div.sv
// ----------------------------------------------------------------------------
// dpt_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dpt_div #(
    parameter int DW = 39,   // dividend and quotient width
    parameter int VW = 16,   // divisor width
    parameter int SW = 1     // sideband width
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [DW-1:0] quotient,
    output logic [SW-1:0] side_out
);

    logic          valid_reg [0:DW];
    logic [VW-1:0] rem_reg   [0:DW];
    logic [DW-1:0] acc_reg   [0:DW];
    logic [VW-1:0] dvs_reg   [0:DW];
    logic [SW-1:0] side_reg  [0:DW];

    // load stage
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            acc_reg[0]  <= dividend;
            dvs_reg[0]  <= divisor;
            side_reg[0] <= side_in;
        end
    end

    // one compare and subtract per stage
    for (genvar k = 1; k <= DW; k++) begin : g_stage
        logic [VW+1:0] trial;
        logic [VW-1:0] rem_next;
        logic          ge;

        always_comb begin
            trial    = {1'b0, rem_reg[k-1], acc_reg[k-1][DW-1]} - {2'b00, dvs_reg[k-1]};
            ge       = !trial[VW+1];
            rem_next = ge ? trial[VW-1:0] : {rem_reg[k-1][VW-2:0], acc_reg[k-1][DW-1]};
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                acc_reg[k]  <= {acc_reg[k-1][DW-2:0], ge};
                dvs_reg[k]  <= dvs_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[DW];
    assign quotient  = acc_reg[DW];
    assign side_out  = side_reg[DW];

endmodule

FILE: sv/dew_point_from_temp_rh_core.sv
// ----------------------------------------------------------------------------
// dew_point_from_temp_rh_core
// Magnus dew point over water from temperature and relative humidity.
// ----------------------------------------------------------------------------
// Usage:
//   sample : valid/ready request with temp_centi_c (0.01 C, signed) and
//            rel_humidity (whole percent, values above 100 read as 100).
//   result : valid/ready request with dew_point_centi_c (0.01 C, signed,
//            truncated toward zero, saturated to 16 bits).
// Throughput: one request per cycle, sustained, while result is taken.
// Pipeline: from sample acceptance to result valid, a sample passes through
//   the two bit-serial divider pipelines (40 and 43 stages) plus four
//   stages for the log lookup and multiplies, gamma sum, second multiply
//   and output saturation.
// Stall: all stages advance together; while a result waits and result.ready
//   is low, the whole pipeline holds and sample.ready is low. Nothing is
//   dropped or repeated.
// Reset: clears all valid bits; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
`include "dew_point_from_temp_rh_core_assert.svh"

module dew_point_from_temp_rh_core (
    input logic     clk,
    input logic     rst_n,
    dpt_in_if.sink  sample,
    dpt_out_if.source result
);
    import dpt_pkg::*;

    localparam int MAG1_W = 39;
    localparam int DEN1_W = 16;
    localparam int GAM_W  = 28;
    localparam int MAG2_W = 42;
    localparam int DEN2_W = 28;

    logic en;

    // stage 1: clamp, log lookup, beta*T
    logic                     s1_valid_reg;
    logic [MAG1_W-1:0]        mag1_reg;
    logic [DEN1_W-1:0]        den1_reg;
    logic                     neg1_reg;
    logic signed [LOG_W-1:0]  lrh1_reg;
    logic [RH_W-1:0]          rh_clamp;
    logic signed [40:0]       prod1;
    logic signed [40:0]       abs1;
    logic signed [16:0]       den1_full;

    // divider 1
    logic                     d1_valid;
    logic [MAG1_W-1:0]        d1_quot;
    logic [LOG_W:0]           d1_side;

    // stage 3: gamma
    logic                     s3_valid_reg;
    logic signed [GAM_W-1:0]  gam3_reg;
    logic signed [GAM_W-1:0]  tq;
    logic signed [GAM_W-1:0]  tdel;

    // stage 4: lambda*gamma and beta-gamma
    logic                     s4_valid_reg;
    logic [MAG2_W-1:0]        mag2_reg;
    logic [DEN2_W-1:0]        den2_reg;
    logic                     neg2_reg;
    logic                     nonpos4_reg;
    logic signed [GAM_W:0]    den2_full;
    logic signed [43:0]       prod2;
    logic signed [43:0]       abs2;
    logic                     nonpos;

    // divider 2
    logic                     d2_valid;
    logic [MAG2_W-1:0]        d2_quot;
    logic [1:0]               d2_side;

    // output register
    logic                     out_valid_reg;
    logic signed [DEW_W-1:0]  out_data_reg;
    logic signed [DEW_W-1:0]  out_data_next;

    assign en           = !out_valid_reg || result.ready;
    assign sample.ready = en;

    // stage 1 logic
    always_comb begin
        rh_clamp  = (sample.rel_humidity > RH_MAX) ? RH_MAX : sample.rel_humidity;
        prod1     = 41'(BETA_Q20) * 41'(sample.temp_centi_c);
        abs1      = prod1[40] ? -prod1 : prod1;
        den1_full = LAMBDA_CENTI + 17'(sample.temp_centi_c);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            mag1_reg <= abs1[MAG1_W-1:0];
            neg1_reg <= prod1[40];
            den1_reg <= den1_full[DEN1_W-1:0];
            lrh1_reg <= signed'(LOG_TAB[rh_clamp]);
        end
    end

    // beta*T / (lambda+T)
    dpt_div #(.DW(MAG1_W), .VW(DEN1_W), .SW(LOG_W + 1)) u_div_tdel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .dividend  (mag1_reg),
        .divisor   (den1_reg),
        .side_in   ({neg1_reg, lrh1_reg}),
        .out_valid (d1_valid),
        .quotient  (d1_quot),
        .side_out  (d1_side)
    );

    // stage 3: signed quotient plus log
    always_comb begin
        tq   = signed'({1'b0, d1_quot[GAM_W-2:0]});
        tdel = d1_side[LOG_W] ? -tq : tq;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            gam3_reg <= tdel + GAM_W'(signed'(d1_side[LOG_W-1:0]));
        end
    end

    // stage 4 logic
    always_comb begin
        den2_full = (GAM_W + 1)'(BETA_Q20) - (GAM_W + 1)'(gam3_reg);
        nonpos    = den2_full[GAM_W] || (den2_full == '0);
        prod2     = 44'(LAMBDA_CENTI) * 44'(gam3_reg);
        abs2      = prod2[43] ? -prod2 : prod2;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            mag2_reg    <= abs2[MAG2_W-1:0];
            neg2_reg    <= prod2[43];
            nonpos4_reg <= nonpos;
            den2_reg    <= nonpos ? DEN2_W'(1) : den2_full[DEN2_W-1:0];
        end
    end

    // lambda*gamma / (beta-gamma)
    dpt_div #(.DW(MAG2_W), .VW(DEN2_W), .SW(2)) u_div_td (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .dividend  (mag2_reg),
        .divisor   (den2_reg),
        .side_in   ({nonpos4_reg, neg2_reg}),
        .out_valid (d2_valid),
        .quotient  (d2_quot),
        .side_out  (d2_side)
    );

    // sign and saturation
    always_comb begin
        priority if (d2_side[1]) begin
            out_data_next = 16'sh7FFF;
        end else if (d2_side[0]) begin
            if (d2_quot >= MAG2_W'(32768)) begin
                out_data_next = -16'sh8000;
            end else begin
                out_data_next = -signed'(d2_quot[DEW_W-1:0]);
            end
        end else if (d2_quot > MAG2_W'(32767)) begin
            out_data_next = 16'sh7FFF;
        end else begin
            out_data_next = signed'(d2_quot[DEW_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            out_data_reg <= out_data_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.dew_point_centi_c = out_data_reg;

    // checks
    `DPT_ASSERT_IMP(a_den_positive, s4_valid_reg, !nonpos4_reg)
    `DPT_ASSERT_NXT(a_stall_holds, !en, $stable(s3_valid_reg) && $stable(gam3_reg))
    `DPT_ASSERT_NXT(a_result_held, result.valid && !result.ready, result.valid)

endmodule

FILE: dv/tb_dew_point_from_temp_rh_core.sv
// ----------------------------------------------------------------------------
// tb_dew_point_from_temp_rh_core
// Drives temperature/humidity readings into the dew point core with random
// gaps and result back-pressure (off in a full-rate last run), predicts each
// Magnus dew point in fixed point, compares every result in order with that.
// ----------------------------------------------------------------------------
module tb_dew_point_from_temp_rh_core;

    timeunit 1ns;
    timeprecision 1ps;

    import dpt_pkg::*;

    localparam int LATENCY   = 87;
    localparam int CYCLE_CAP = 400000;

    logic clk;
    logic rst_n;

    dpt_in_if  sample ();
    dpt_out_if result ();

    dew_point_from_temp_rh_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source)
    );

    logic signed [15:0] dew_q[$];
    int                 err_cnt;
    int                 cyc;
    bit                 gaps_on;

    always #5 clk = ~clk;

    // ln(RH/100) in Q4.20, fast log with quadratic on the mantissa
    function automatic longint ln_pct(input logic [6:0] rh_in);
        longint rh;
        longint sh;
        longint mant;
        longint quad;
        longint acc;
        rh = (rh_in > RH_MAX) ? 100 : longint'(rh_in);
        if (rh == 0)
            return -5 * 1048576;
        sh = 0;
        while (sh < 7 && (rh << sh) < 100)
            sh++;
        mant = (rh << (20 + sh)) / 100;
        quad = (((2 * 1048576 - mant / 3) * mant) >>> 20) - 699050;
        acc  = (quad + (-sh - 1) * 1048576) * 726663;
        return acc / 1048576;
    endfunction

    // Magnus dew point, truncated toward zero and saturated to 16 bits
    function automatic logic signed [15:0] dew_point(input logic signed [14:0] tc,
                                                     input logic [6:0] rh);
        longint t;
        longint gam;
        longint den;
        longint td;
        t   = longint'(tc);
        gam = ln_pct(rh) + (64'sd18475909 * t) / (24312 + t);
        den = 64'sd18475909 - gam;
        td  = (den <= 0) ? 32767 : (24312 * gam) / den;
        if (td > 32767)
            td = 32767;
        if (td < -32768)
            td = -32768;
        return 16'(td);
    endfunction

    // one request: optional gap, then hold valid until accepted
    task automatic send_reading(input logic signed [14:0] tc, input logic [6:0] rh);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            sample.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        sample.valid        <= 1'b1;
        sample.temp_centi_c <= tc;
        sample.rel_humidity <= rh;
        do
            @(posedge clk);
        while (!sample.ready);
        dew_q.push_back(dew_point(tc, rh));
    endtask

    // bursts of back-pressure on the result side
    initial
    begin
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            result.ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            if (dew_q.size() == 0)
            begin
                $display("%0t: unexpected dew point, expected none, actual %0d",
                         $time, result.dew_point_centi_c);
                err_cnt++;
            end
            else if (result.dew_point_centi_c !== dew_q[0])
            begin
                $display("%0t: dew point mismatch, expected %0d, actual %0d",
                         $time, dew_q[0], result.dew_point_centi_c);
                err_cnt++;
                void'(dew_q.pop_front());
            end
            else
                void'(dew_q.pop_front());
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cyc++;
        if (cyc > CYCLE_CAP)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_directed();
        logic signed [14:0] temps[6];
        logic [6:0]         hums[4];
        temps = '{-15'sd4000, 15'sd12500, 15'sd0, -15'sd16384, 15'sd16383, 15'sd2000};
        hums  = '{7'd0, 7'd100, 7'd127, 7'd1};
        foreach (temps[i])
            foreach (hums[j])
                send_reading(temps[i], hums[j]);
    endtask

    task automatic test_random(input int n);
        logic signed [14:0] tc;
        logic [6:0]         rh;
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                tc = 15'($urandom);
                rh = 7'($urandom);
            end
            else
            begin
                tc = 15'($signed($urandom_range(0, 16500)) - 4000);
                rh = 7'($urandom_range(0, 100));
            end
            send_reading(tc, rh);
        end
    endtask

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        sample.valid        = 1'b0;
        sample.temp_centi_c = '0;
        sample.rel_humidity = '0;
        err_cnt             = 0;
        cyc                 = 0;
        gaps_on             = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1500);
        // last stretch at full rate
        gaps_on = 1'b0;
        test_random(326);
        sample.valid <= 1'b0;
        while (dew_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
